// ===== design/psg_three_voice_sound_generator_macros.svh =====
// Assertion macros shared by the sound generator modules.
// Depends on nothing; included by files that carry assertions.
`ifndef PSG_THREE_VOICE_SOUND_GENERATOR_MACROS_SVH
`define PSG_THREE_VOICE_SOUND_GENERATOR_MACROS_SVH
// implication checked on every clock edge outside reset
`define PSG_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("psg assertion failed");
// implication whose consequent is checked in the cycle after the antecedent
`define PSG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("psg assertion failed");
`endif

// ===== design/psg_pkg.sv =====
// Types and constants of the sound generator: codes, queue entry, volume curves, pan gains.
// No dependencies.
`timescale 1ns / 1ps
package psg_pkg;
	localparam logic [1:0] KIND_SELECT = 2'd0;
	localparam logic [1:0] KIND_WRITE  = 2'd1;
	localparam logic [1:0] KIND_READ   = 2'd2;
	localparam logic [1:0] KIND_TICK   = 2'd3;

	localparam logic [1:0] CFG_CHIP_KIND    = 2'd0;
	localparam logic [1:0] CFG_VOLUME_CURVE = 2'd1;
	localparam logic [1:0] CFG_PAN_MODE     = 2'd2;

	localparam int QDEPTH = 2;

	// classified transaction handed from the front to the back
	typedef struct packed {
		logic       is_tick;
		logic       is_write;
		logic       is_read;
		logic       sel_valid;
		logic [3:0] sel;
		logic [7:0] data;
	} cmd_t;

	function automatic logic [15:0] curve_lut(input logic ym, input logic [4:0] a);
		logic [15:0] r;
		if (!ym) begin
			case (a[4:1])
				4'd0: r = 16'h0000; 4'd1: r = 16'h0340; 4'd2: r = 16'h04C0;
				4'd3: r = 16'h06F2; 4'd4: r = 16'h0A44; 4'd5: r = 16'h0F13;
				4'd6: r = 16'h1510; 4'd7: r = 16'h227E; 4'd8: r = 16'h289F;
				4'd9: r = 16'h414E; 4'd10: r = 16'h5B21; 4'd11: r = 16'h7258;
				4'd12: r = 16'h905E; 4'd13: r = 16'hB550; 4'd14: r = 16'hD7A0;
				default: r = 16'hFFFF;
			endcase
		end else begin
			case (a)
				5'd0: r = 16'h0000; 5'd1: r = 16'h0000; 5'd2: r = 16'h00EF;
				5'd3: r = 16'h01D0; 5'd4: r = 16'h0290; 5'd5: r = 16'h032A;
				5'd6: r = 16'h03EE; 5'd7: r = 16'h04D2; 5'd8: r = 16'h0611;
				5'd9: r = 16'h0782; 5'd10: r = 16'h0912; 5'd11: r = 16'h0A36;
				5'd12: r = 16'h0C31; 5'd13: r = 16'h0EB6; 5'd14: r = 16'h1130;
				5'd15: r = 16'h13A0; 5'd16: r = 16'h1751; 5'd17: r = 16'h1BF5;
				5'd18: r = 16'h20E2; 5'd19: r = 16'h2594; 5'd20: r = 16'h2CA1;
				5'd21: r = 16'h357F; 5'd22: r = 16'h3E45; 5'd23: r = 16'h475E;
				5'd24: r = 16'h5502; 5'd25: r = 16'h6620; 5'd26: r = 16'h7730;
				5'd27: r = 16'h8844; 5'd28: r = 16'hA1D2; 5'd29: r = 16'hC102;
				5'd30: r = 16'hE0A2; default: r = 16'hFFFF;
			endcase
		end
		return r;
	endfunction

	// position code: 0 mono, 1 left, 2 middle, 3 right
	function automatic logic [1:0] pan_pos(input logic [2:0] mode, input logic [1:0] ch);
		logic [8:0] row;
		case (mode)
			3'd1: row = {3'd3, 3'd2, 3'd1};
			3'd2: row = {3'd2, 3'd3, 3'd1};
			3'd3: row = {3'd3, 3'd1, 3'd2};
			3'd4: row = {3'd2, 3'd1, 3'd3};
			3'd5: row = {3'd1, 3'd3, 3'd2};
			3'd6: row = {3'd1, 3'd2, 3'd3};
			default: row = 9'd0;
		endcase
		case (ch)
			2'd0: return row[1:0];
			2'd1: return row[4:3];
			default: return row[7:6];
		endcase
	endfunction

	function automatic logic [15:0] gain_l(input logic [1:0] p);
		case (p)
			2'd1: return 16'd37137;
			2'd2: return 16'd24030;
			2'd3: return 16'd4369;
			default: return 16'd21845;
		endcase
	endfunction

	function automatic logic [15:0] gain_r(input logic [1:0] p);
		case (p)
			2'd1: return 16'd4369;
			2'd2: return 16'd24030;
			2'd3: return 16'd37137;
			default: return 16'd21845;
		endcase
	endfunction
endpackage

// ===== design/psg_three_voice_sound_generator.sv =====
// Top level of the three-voice sound generator: config registers, front, queue, back.
// Depends on psg_pkg, psg_front, psg_queue, psg_back.
`timescale 1ns / 1ps
// One transaction per cycle is taken whenever the two-entry queue has room; select items
// finish in the front, writes take effect in the back when popped from the queue, and reads
// and ticks pass through the queue and stage 1 (tick update and volume lookup at the pop),
// then gain multiply and sum into the output register. The output register and queue let
// input keep flowing while a result waits, until the queue is full.
module psg_three_voice_sound_generator import psg_pkg::*; #(
	parameter int OUTPUT_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [2:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  kind,
	input  logic [7:0]  bus_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        is_sample,
	output logic [7:0]  read_data,
	output logic [15:0] left_level,
	output logic [15:0] right_level
);
	logic       chip_kind_q, curve_q;
	logic [2:0] pan_q;
	logic       push, full, empty, pop, in_fire;
	cmd_t       cmd, qcmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chip_kind_q <= 1'b0;
			curve_q     <= 1'b0;
			pan_q       <= 3'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_CHIP_KIND:    chip_kind_q <= cfg_data[0];
				CFG_VOLUME_CURVE: curve_q <= cfg_data[0];
				CFG_PAN_MODE:     pan_q <= cfg_data;
				default:          ;
			endcase
		end
	end

	assign in_stall = full;
	assign in_fire  = in_valid && !full;

	psg_front u_front (.clk, .arst_n, .chip_kind(chip_kind_q), .in_fire, .kind, .bus_data,
		.push, .cmd);

	psg_queue u_queue (.clk, .arst_n, .push, .din(cmd), .full, .pop, .empty, .dout(qcmd));

	psg_back #(.OUTPUT_BITS(OUTPUT_BITS)) u_back (.clk, .arst_n, .volume_curve(curve_q),
		.pan_mode(pan_q), .q_empty(empty), .q_cmd(qcmd), .pop, .out_valid, .out_stall,
		.is_sample, .read_data, .left_level, .right_level);
endmodule

// ===== design/psg_front.sv =====
// Front end: takes bus transactions, tracks the selected register, classifies items.
// Depends on psg_pkg.
`timescale 1ns / 1ps
module psg_front import psg_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       chip_kind,
	input  logic       in_fire,
	input  logic [1:0] kind,
	input  logic [7:0] bus_data,
	output logic       push,
	output cmd_t       cmd
);
	logic [7:0] sel_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q <= '0;
		end else if (in_fire && kind == KIND_SELECT) begin
			sel_q <= chip_kind ? bus_data : {4'd0, bus_data[3:0]};
		end
	end

	always_comb begin
		push          = in_fire && kind != KIND_SELECT;
		cmd.is_tick   = kind == KIND_TICK;
		cmd.is_write  = kind == KIND_WRITE;
		cmd.is_read   = kind == KIND_READ;
		cmd.sel_valid = sel_q[7:4] == 4'd0;
		cmd.sel       = sel_q[3:0];
		cmd.data      = bus_data;
	end
endmodule

// ===== design/psg_queue.sv =====
// Short queue between front and back.
// Depends on psg_pkg and the assertion macros header.
`timescale 1ns / 1ps
`include "psg_three_voice_sound_generator_macros.svh"
module psg_queue import psg_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t din,
	output logic full,
	input  logic pop,
	output logic empty,
	output cmd_t dout
);
	cmd_t       mem_q [QDEPTH];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full  = cnt_q == 2'(QDEPTH);
	assign empty = cnt_q == 2'd0;
	assign dout  = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	`PSG_ASSERT_IMP(a_no_overflow, clk, arst_n, full, !push)
	`PSG_ASSERT_IMP(a_no_underflow, clk, arst_n, empty, !pop)
	`PSG_ASSERT_NEXT(a_cnt_hold, clk, arst_n, push == pop, cnt_q == $past(cnt_q))
endmodule

// ===== design/psg_back.sv =====
// Back end: register file, tone/noise/envelope generators, mixer and output register.
// Depends on psg_pkg and the assertion macros header.
`timescale 1ns / 1ps
`include "psg_three_voice_sound_generator_macros.svh"
module psg_back import psg_pkg::*; #(
	parameter int OUTPUT_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        volume_curve,
	input  logic [2:0]  pan_mode,
	input  logic        q_empty,
	input  cmd_t        q_cmd,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        is_sample,
	output logic [7:0]  read_data,
	output logic [15:0] left_level,
	output logic [15:0] right_level
);
	localparam logic [17:0] TOP = 18'((64'd1 << OUTPUT_BITS) - 64'd1);

	logic [7:0]  regs_q [16];
	logic [11:0] tcnt_q [3];
	logic [2:0]  tlev_q;
	logic [5:0]  ncnt_q;
	logic [16:0] nsh_q;
	logic        nlev_q;
	logic [15:0] ecnt_q;
	logic [5:0]  elev_q;
	logic [1:0]  estep_q;

	// mix stage: stage 1 holds per-channel volumes and pan positions after the tick
	logic        v_s1, smp_s1;
	logic [7:0]  rd_s1;
	logic [15:0] vol_s1 [3];
	logic [1:0]  pos_s1 [3];
	logic        ovalid_q, osmp_q;
	logic [7:0]  ord_q;
	logic [15:0] ol_q, or_q;

	logic        advance, go, is_out;
	logic [2:0]  tlev_n;
	logic [11:0] tcnt_n [3];
	logic [5:0]  ncnt_n;
	logic [16:0] nsh_n;
	logic        nlev_n;
	logic [15:0] ecnt_n;
	logic [5:0]  elev_n, lv;
	logic [1:0]  estep_n;
	logic [15:0] shm;
	logic [7:0]  wdata;
	logic [17:0] suml, sumr;

	assign advance = !ovalid_q || !out_stall;
	assign go      = !q_empty && advance;
	assign pop     = go;
	assign is_out  = q_cmd.is_tick || q_cmd.is_read;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			tcnt_n[c] = tcnt_q[c] + 12'd1;
			tlev_n[c] = tlev_q[c];
			if (tcnt_n[c] >= {regs_q[2*c+1][3:0], regs_q[2*c]}) begin
				tcnt_n[c] = '0;
				tlev_n[c] = ~tlev_q[c];
			end
		end
		ncnt_n = ncnt_q + 6'd1;
		nsh_n  = nsh_q;
		nlev_n = nlev_q;
		if (ncnt_n >= {regs_q[6][4:0], 1'b0}) begin
			ncnt_n = '0;
			nsh_n  = {nsh_q[15:0], 1'b1} ^ {16'd0, nsh_q[16] ^ nsh_q[13]};
			nlev_n = nsh_n[16];
		end
		ecnt_n  = ecnt_q + 16'd1;
		elev_n  = elev_q;
		estep_n = estep_q;
		shm     = 16'd1 << regs_q[13][3:0];
		lv      = '0;
		if ({16'd0, ecnt_n} >= {16'd0, regs_q[12], regs_q[11]}) begin
			ecnt_n = '0;
			lv     = elev_q + {{4{estep_q[1]}}, estep_q};
			elev_n = lv;
			if (lv[5]) begin
				if ((shm & 16'h82FF) != 16'd0) begin
					elev_n  = '0;
					estep_n = '0;
				end else if ((shm & 16'h1100) != 16'd0) begin
					elev_n = {1'b0, lv[4:0]};
				end else if ((shm & 16'h4400) != 16'd0) begin
					estep_n = -estep_q;
					elev_n  = lv - {{4{estep_q[1]}}, estep_q};
				end else begin
					elev_n  = 6'd31;
					estep_n = '0;
				end
			end
		end
	end

	always_comb begin
		case (q_cmd.sel)
			4'd1, 4'd3, 4'd5, 4'd13: wdata = {4'd0, q_cmd.data[3:0]};
			4'd6, 4'd8, 4'd9, 4'd10: wdata = {3'd0, q_cmd.data[4:0]};
			default:                 wdata = q_cmd.data;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 16; i++) regs_q[i] <= '0;
			for (int c = 0; c < 3; c++) tcnt_q[c] <= '0;
			tlev_q  <= '0;
			ncnt_q  <= '0;
			nsh_q   <= '0;
			nlev_q  <= 1'b0;
			ecnt_q  <= '0;
			elev_q  <= 6'd31;
			estep_q <= 2'b11;
		end else if (go && q_cmd.is_write && q_cmd.sel_valid) begin
			regs_q[q_cmd.sel] <= wdata;
			if (q_cmd.sel == 4'd13) begin
				ecnt_q  <= '0;
				elev_q  <= wdata[2] ? 6'd0 : 6'd31;
				estep_q <= wdata[2] ? 2'b01 : 2'b11;
			end
		end else if (go && q_cmd.is_tick) begin
			for (int c = 0; c < 3; c++) tcnt_q[c] <= tcnt_n[c];
			tlev_q  <= tlev_n;
			ncnt_q  <= ncnt_n;
			nsh_q   <= nsh_n;
			nlev_q  <= nlev_n;
			ecnt_q  <= ecnt_n;
			elev_q  <= elev_n;
			estep_q <= estep_n;
		end
	end

	// stage 1: volume lookup from post-tick state, and read data capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (advance) begin
			v_s1 <= go && is_out;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			smp_s1 <= q_cmd.is_tick;
			rd_s1  <= q_cmd.sel_valid ? regs_q[q_cmd.sel] : 8'hFF;
			for (int c = 0; c < 3; c++) begin
				logic [4:0] amp;
				amp = regs_q[8+c][4] ? elev_n[4:0] : {regs_q[8+c][3:0], 1'b1};
				if (!((tlev_n[c] || regs_q[7][c]) && (nlev_n || regs_q[7][c+3])))
					amp = '0;
				vol_s1[c] <= curve_lut(volume_curve, amp);
				pos_s1[c] <= pan_pos(pan_mode, 2'(c));
			end
		end
	end

	always_comb begin
		logic [31:0] pl, pr;
		suml = '0;
		sumr = '0;
		for (int c = 0; c < 3; c++) begin
			pl = vol_s1[c] * gain_l(pos_s1[c]);
			pr = vol_s1[c] * gain_r(pos_s1[c]);
			suml = suml + {2'd0, pl[31:16]};
			sumr = sumr + {2'd0, pr[31:16]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (advance) begin
			ovalid_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			osmp_q <= smp_s1;
			ord_q  <= smp_s1 ? 8'd0 : rd_s1;
			ol_q   <= smp_s1 ? (suml > TOP ? TOP[15:0] : suml[15:0]) : 16'd0;
			or_q   <= smp_s1 ? (sumr > TOP ? TOP[15:0] : sumr[15:0]) : 16'd0;
		end
	end

	assign out_valid   = ovalid_q;
	assign is_sample   = osmp_q;
	assign read_data   = ord_q;
	assign left_level  = ol_q;
	assign right_level = or_q;

	`PSG_ASSERT_NEXT(a_hold, clk, arst_n, ovalid_q && out_stall, ovalid_q && $stable(ord_q))
	`PSG_ASSERT_IMP(a_env_range, clk, arst_n, 1'b1, !elev_q[5])
	`PSG_ASSERT_IMP(a_read_zero, clk, arst_n, ovalid_q && osmp_q, ord_q == 8'd0)
endmodule
